/* hw/rtl/tds_pkg.sv */
package tds_pkg;

    localparam int RowW    = 32;
    localparam int TileW   = 256;
    localparam int PalW    = 4;
    localparam int IndexW  = 8;
    localparam int AddrW   = 1;

    localparam logic [AddrW-1:0] RegPaletteSearch = 1'b0;
    localparam logic [AddrW-1:0] RegFlipSearch    = 1'b1;

    typedef struct packed {
        logic [RowW-1:0] row_7;
        logic [RowW-1:0] row_6;
        logic [RowW-1:0] row_5;
        logic [RowW-1:0] row_4;
        logic [RowW-1:0] row_3;
        logic [RowW-1:0] row_2;
        logic [RowW-1:0] row_1;
        logic [RowW-1:0] row_0;
        logic [PalW-1:0] tile_palette;
        logic            in_hflip;
        logic            in_vflip;
    } in_word_t;

    typedef struct packed {
        logic [IndexW-1:0] tile_index;
        logic              out_vflip;
        logic              out_hflip;
        logic [PalW-1:0]   out_palette;
        logic              is_new;
        logic              store_full;
    } out_word_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input word, render it
        logic scan_rst;  // restart entry scan
        logic scan_adv;  // read next entry
        logic append;    // write rendered tile
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;       // registered: an entry compared since scan restart matched
        logic last;      // entry just compared was the last stored one
        logic empty;     // store holds no entries
        logic full;      // store holds MAX_TILES entries
    } dp_sts_t;

    function automatic logic [RowW-1:0] mirror_row(input logic [RowW-1:0] r);
        logic [RowW-1:0] o;
        o = '0;
        for (int x = 0; x < 8; x++)
        begin
            o[4*(7-x) +: 4] = r[4*x +: 4];
        end
        return o;
    endfunction

    // tile packed with row y at bits 32y+31..32y
    function automatic logic [TileW-1:0] orient(input logic [TileW-1:0] t,
                                                input logic v, input logic h);
        logic [TileW-1:0] o;
        logic [RowW-1:0]  r;
        o = '0;
        for (int y = 0; y < 8; y++)
        begin
            r = h ? mirror_row(t[RowW*y +: RowW]) : t[RowW*y +: RowW];
            if (v)
                o[RowW*(7-y) +: RowW] = r;
            else
                o[RowW*y +: RowW] = r;
        end
        return o;
    endfunction

endpackage

/* hw/rtl/tds_if.sv */
interface tds_in_if;
    logic              valid;
    logic              ready;
    tds_pkg::in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tds_out_if;
    logic               valid;
    logic               ready;
    tds_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/tds_dp.sv */
module tds_dp #(
    parameter int MAX_TILES = 256,
    parameter int PALETTES  = 16,
    parameter int CntW      = 9
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tds_pkg::in_word_t  in_data,
    input  tds_pkg::dp_cmd_t   cmd,
    input  logic               palette_search,
    input  logic               flip_search,
    output tds_pkg::dp_sts_t   sts,
    output tds_pkg::out_word_t res
);
    localparam int IdxW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;

    logic [tds_pkg::TileW-1:0] pix_mem [MAX_TILES];
    logic [tds_pkg::PalW-1:0]  pal_mem [MAX_TILES];

    logic [tds_pkg::TileW-1:0] rend_reg;
    logic [tds_pkg::PalW-1:0]  pal_reg;
    logic [CntW-1:0]           count_reg;
    logic [CntW-1:0]           scan_reg;
    logic [CntW-1:0]           rd_idx_reg;
    logic [tds_pkg::TileW-1:0] rd_pix_reg;
    logic [tds_pkg::PalW-1:0]  rd_pal_reg;
    logic                      rd_vld_reg;
    logic                      rd_last_reg;
    logic [tds_pkg::TileW-1:0] rend_next;
    logic [tds_pkg::TileW-1:0] rows;
    logic                      hit_pal;
    logic                      hv0, hv1, hv2, hv3;
    logic [1:0]                best_t;
    logic                      any;
    logic                      res_hit_reg;
    logic [CntW-1:0]           res_idx_reg;
    logic [1:0]                res_t_reg;
    logic [tds_pkg::PalW-1:0]  best_pal_reg;
    logic                      hit_next;
    logic                      better;

    assign rows = {in_data.row_7, in_data.row_6, in_data.row_5, in_data.row_4,
                   in_data.row_3, in_data.row_2, in_data.row_1, in_data.row_0};
    assign rend_next = tds_pkg::orient(rows, in_data.in_vflip, in_data.in_hflip);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rend_reg <= rend_next;
            pal_reg  <= in_data.tile_palette;
        end
        if (cmd.append)
        begin
            pix_mem[count_reg[IdxW-1:0]] <= rend_reg;
            pal_mem[count_reg[IdxW-1:0]] <= pal_reg;
        end
        rd_pix_reg <= pix_mem[scan_reg[IdxW-1:0]];
        rd_pal_reg <= pal_mem[scan_reg[IdxW-1:0]];
        rd_idx_reg <= scan_reg;
    end

    // The four candidate orientations of the rendered tile versus the read entry.
    assign hit_pal = (palette_search || (rd_pal_reg == pal_reg))
                     && ({1'b0, rd_pal_reg} < 5'(PALETTES))
                     && ({1'b0, pal_reg} < 5'(PALETTES) || palette_search);
    assign hv0 = rd_pix_reg == rend_reg;
    assign hv1 = flip_search && (rd_pix_reg == tds_pkg::orient(rend_reg, 1'b1, 1'b0));
    assign hv2 = flip_search && (rd_pix_reg == tds_pkg::orient(rend_reg, 1'b0, 1'b1));
    assign hv3 = flip_search && (rd_pix_reg == tds_pkg::orient(rend_reg, 1'b1, 1'b1));
    assign any = rd_vld_reg && hit_pal && (hv0 || hv1 || hv2 || hv3);

    always_comb
    begin
        priority if (hv0)
            best_t = 2'd0;
        else if (hv1)
            best_t = 2'd1;
        else if (hv2)
            best_t = 2'd2;
        else
            best_t = 2'd3;
    end

    // Ranking: palette-major, then orientation, then index.
    always_comb
    begin
        better = 1'b0;
        if (any)
        begin
            if (!res_hit_reg)
                better = 1'b1;
            else if (rd_pal_reg != best_pal_reg)
                better = rd_pal_reg < best_pal_reg;
            else
                better = best_t < res_t_reg;
        end
    end
    assign hit_next = res_hit_reg || any;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            scan_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            res_hit_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= cmd.scan_adv;
            rd_last_reg <= cmd.scan_adv && (scan_reg + 1'b1 == count_reg);
            if (cmd.scan_rst)
                scan_reg <= '0;
            else if (cmd.scan_adv)
                scan_reg <= scan_reg + 1'b1;
            if (cmd.scan_rst)
                res_hit_reg <= 1'b0;
            else
                res_hit_reg <= hit_next;
            if (cmd.append)
                count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (better)
        begin
            res_idx_reg  <= rd_idx_reg;
            res_t_reg    <= best_t;
            best_pal_reg <= rd_pal_reg;
        end
    end

    assign sts.hit   = res_hit_reg;
    assign sts.last  = rd_last_reg;
    assign sts.empty = count_reg == '0;
    assign sts.full  = count_reg == CntW'(MAX_TILES);

    always_comb
    begin
        res.out_palette = pal_reg;
        res.store_full  = 1'b0;
        res.is_new      = 1'b0;
        res.out_vflip   = 1'b0;
        res.out_hflip   = 1'b0;
        if (res_hit_reg)
        begin
            res.tile_index = res_idx_reg[tds_pkg::IndexW-1:0];
            res.out_vflip  = res_t_reg[0];
            res.out_hflip  = res_t_reg[1];
        end
        else if (count_reg != CntW'(MAX_TILES))
        begin
            res.tile_index = count_reg[tds_pkg::IndexW-1:0];
            res.is_new     = 1'b1;
        end
        else
        begin
            res.tile_index = '0;
            res.store_full = 1'b1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> count_reg < CntW'(MAX_TILES))
        else $error("append into a full store");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |=> count_reg == $past(count_reg) + 1'b1)
        else $error("fill count did not advance");
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(MAX_TILES))
        else $error("fill count overflow");
endmodule

/* hw/rtl/tds_ctrl.sv */
module tds_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  tds_pkg::dp_sts_t sts,
    output tds_pkg::dp_cmd_t cmd
);
    typedef enum logic [2:0] {S_IDLE, S_START, S_SCAN, S_DRAIN, S_DONE, S_OUT} state_t;
    state_t state_reg;
    logic   out_valid_reg;
    logic   app_reg;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign cmd.load     = in_valid && in_ready;
    assign cmd.scan_rst = state_reg == S_IDLE;
    assign cmd.scan_adv = state_reg == S_SCAN && !sts.last;
    assign cmd.append   = app_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            app_reg       <= 1'b0;
        end
        else
        begin
            app_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                        state_reg <= S_START;
                S_START:
                    state_reg <= sts.empty ? S_DRAIN : S_SCAN;
                S_SCAN:
                    if (sts.last)
                        state_reg <= S_DRAIN;
                S_DRAIN:
                    state_reg <= S_DONE;
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        app_reg       <= !sts.hit && !sts.full;
                        state_reg     <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == S_OUT)
        else $error("result shown outside output state");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !in_ready)
        else $error("second word accepted while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        app_reg |-> state_reg == S_IDLE)
        else $error("append during scan");
endmodule

/* hw/rtl/tile_dedup_with_flip_search_unit.sv */
// Channel   Dir  Payload                                     Handshake
// in_ch     in   row_0..row_7, tile_palette, in_hflip/vflip  valid/ready
// out_ch    out  tile_index, flips, out_palette, is_new, ...  valid/ready
// apb       in   palette_search @0x0, flip_search @0x4       psel/penable
//
// Each word is checked by an entry scan that reads one stored tile per cycle
// from the tile memory; the scan is skipped with an empty store, and the result
// is shown once the scan has drained.
// Reset clears the fill count; the tile memory needs no clearing pass.
// A stalled output holds the result; the next word is taken after it leaves.
module tile_dedup_with_flip_search_unit #(
    parameter int MAX_TILES = 256,
    parameter int PALETTES  = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    tds_in_if.sink        in_ch,
    tds_out_if.source     out_ch,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    localparam int CntW = $clog2(MAX_TILES + 1);

    tds_pkg::dp_cmd_t cmd;
    tds_pkg::dp_sts_t sts;
    logic palette_search_reg;
    logic flip_search_reg;

    // Config registers, written at the access phase.
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_search_reg <= 1'b0;
            flip_search_reg    <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == tds_pkg::RegPaletteSearch)
                palette_search_reg <= pwdata[0];
            else
                flip_search_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == tds_pkg::RegFlipSearch)
            prdata[0] = flip_search_reg;
        else
            prdata[0] = palette_search_reg;
    end

    tds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tds_dp #(
        .MAX_TILES (MAX_TILES),
        .PALETTES  (PALETTES),
        .CntW      (CntW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_data        (in_ch.data),
        .cmd            (cmd),
        .palette_search (palette_search_reg),
        .flip_search    (flip_search_reg),
        .sts            (sts),
        .res            (out_ch.data)
    );
endmodule
